// File: design/sspr_pkg.sv
// Package for the servo status packet receiver.
// Holds request and status codes, queue sizing and the payload structs.
// No dependencies.
package sspr_pkg;

	localparam logic [1:0] REQ_ARM  = 2'd0;
	localparam logic [1:0] REQ_BYTE = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TIMEOUT  = 2'd1;
	localparam logic [1:0] ST_CSUM_ERR = 2'd2;

	localparam logic [7:0] TIMEOUT_RESET = 8'd20;
	localparam logic [8:0] LEN_POS       = 9'd3;
	localparam logic [8:0] LEN_EXTRA     = 9'd4;
	localparam logic [8:0] SUM_FIRST     = 9'd2;
	localparam logic [8:0] POS_MAX       = 9'h1FF;
	localparam logic [7:0] IDLE_MAX      = 8'hFF;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_ARM,
		OP_BYTE,
		OP_TICK
	} op_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [8:0] byte_index;
		logic [7:0] byte_value;
		logic [1:0] status;
		logic       last;
	} out_item_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

endpackage

// File: design/sspr_front.sv
// Front end of the servo status packet receiver: accepts input transfers
// and classifies them into queue commands. Unused request codes are dropped.
// Depends on sspr_pkg.
module sspr_front (
	input  logic              in_valid,
	output logic              in_stall,
	input  sspr_pkg::in_item_t in_data,
	input  logic              q_full,
	output logic              push,
	output sspr_pkg::cmd_t    push_cmd
);
	import sspr_pkg::*;

	logic known;

	assign in_stall = q_full;

	always_comb begin
		known         = 1'b1;
		push_cmd.data = in_data.rx_byte;
		case (in_data.req_type)
			REQ_ARM:  push_cmd.op = OP_ARM;
			REQ_BYTE: push_cmd.op = OP_BYTE;
			REQ_TICK: push_cmd.op = OP_TICK;
			default: begin
				push_cmd.op = OP_TICK;
				known       = 1'b0;
			end
		endcase
	end

	assign push = in_valid && !q_full && known;

endmodule

// File: design/sspr_queue.sv
// Short command queue between front and back end.
// Register-based FIFO sized by QUEUE_DEPTH. Depends on sspr_pkg.
module sspr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sspr_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           avail,
	output sspr_pkg::cmd_t head
);
	import sspr_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign avail  = (count_q != '0);
	assign head   = mem_q[rd_ptr_q];
	assign do_pop = pop && avail;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/sspr_back.sv
// Back end of the servo status packet receiver: executes queued commands,
// tracks packet position, checksum and idle ticks, drives the output register.
// Depends on sspr_pkg.
module sspr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         timeout_ticks,
	input  logic               q_avail,
	input  sspr_pkg::cmd_t     q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output sspr_pkg::out_item_t out_data
);
	import sspr_pkg::*;

	logic       armed_q;
	logic [8:0] position_q;
	logic [8:0] total_q;
	logic [7:0] sum_q;
	logic [7:0] idle_q;
	logic       out_valid_q;
	out_item_t  out_data_q;

	logic       out_free;
	logic [8:0] tot_new;
	logic [9:0] pos_inc;
	logic       final_byte;
	logic [7:0] idle_new;
	logic       emit;
	out_item_t  res;

	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = q_avail && out_free;

	assign tot_new    = (position_q == LEN_POS) ? ({1'b0, q_head.data} + LEN_EXTRA) : total_q;
	assign pos_inc    = {1'b0, position_q} + 10'd1;
	assign final_byte = (position_q >= LEN_POS) && (pos_inc == {1'b0, tot_new});
	assign idle_new   = (idle_q < IDLE_MAX) ? idle_q + 8'd1 : idle_q;

	always_comb begin
		emit = 1'b0;
		res  = '{byte_index: position_q, byte_value: q_head.data, status: ST_OK, last: 1'b0};
		case (q_head.op)
			OP_BYTE: begin
				emit = armed_q;
				if (final_byte) begin
					res.last   = 1'b1;
					res.status = (~sum_q == q_head.data) ? ST_OK : ST_CSUM_ERR;
				end
			end
			OP_TICK: begin
				emit           = armed_q && (idle_new >= timeout_ticks);
				res.byte_value = 8'd0;
				res.status     = ST_TIMEOUT;
				res.last       = 1'b1;
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			position_q  <= '0;
			total_q     <= '0;
			sum_q       <= '0;
			idle_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				case (q_head.op)
					OP_ARM: begin
						armed_q    <= 1'b1;
						position_q <= '0;
						total_q    <= '0;
						sum_q      <= '0;
						idle_q     <= '0;
					end
					OP_BYTE: begin
						if (armed_q) begin
							idle_q  <= '0;
							total_q <= tot_new;
							if (final_byte) begin
								armed_q <= 1'b0;
							end else begin
								if (position_q >= SUM_FIRST) begin
									sum_q <= sum_q + q_head.data;
								end
								if (position_q != POS_MAX) begin
									position_q <= pos_inc[8:0];
								end
							end
						end
					end
					OP_TICK: begin
						if (armed_q) begin
							idle_q <= idle_new;
							if (idle_new >= timeout_ticks) begin
								armed_q <= 1'b0;
							end
						end
					end
					default: armed_q <= armed_q;
				endcase
			end
			if (q_pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: design/servo_status_packet_receiver.sv
// Servo status packet receiver, top level.
// Ties front end, command queue and back end; holds the timeout register.
// Depends on sspr_pkg, sspr_front, sspr_queue, sspr_back.
//
// Takes one transfer per cycle while in_stall is low: arm, received byte or
// timer tick. Each byte received while armed is echoed with its index; the
// final byte (index length + 3) and a timeout are flagged last with their
// status. A byte or tick passes the front end, a 4-entry queue and the back
// end's output register; the back end takes one item per cycle unless
// out_stall holds its output. in_stall rises only when the queue is full,
// which happens while out_stall holds the output.
module servo_status_packet_receiver (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sspr_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output sspr_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata
);
	import sspr_pkg::*;

	logic [7:0] timeout_q;
	logic       push;
	cmd_t       push_cmd;
	logic       q_full;
	logic       q_pop;
	logic       q_avail;
	cmd_t       q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	sspr_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	sspr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.head     (q_head)
	);

	sspr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.timeout_ticks (timeout_q),
		.q_avail       (q_avail),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data)
	);

endmodule

// File: design/sspr_checker.sv
// Port-level checker for the servo status packet receiver, with bind.
// Depends on sspr_pkg and servo_status_packet_receiver.
module sspr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input sspr_pkg::out_item_t out_data
);
	import sspr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output transfer changed");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != ST_OK) |-> out_data.last)
		else $error("error status without last");

	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_TIMEOUT) |-> (out_data.byte_value == 8'd0))
		else $error("timeout carries a byte value");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last && (out_data.status != ST_TIMEOUT)
		|-> (out_data.byte_index >= LEN_POS))
		else $error("packet ended before length byte");

endmodule

bind servo_status_packet_receiver sspr_checker u_sspr_checker (.*);
